// ----- rtl/core/csvft_pkg.sv -----
// ----------------------------------------------------------------------------
// csvft_pkg: shared types and constants for the csv field tokenizer
// Result kinds, status codes, character codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package csvft_pkg;

  localparam int unsigned ColumnBitsDef = 16;
  localparam int unsigned RowBitsDef    = 24;

  // fixed result field widths
  localparam int unsigned ColOutBits = 16;
  localparam int unsigned RowOutBits = 24;

  // up to three results come out of one input word
  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_FIELD_END = 3'd1,
    KIND_ROW_END   = 3'd2,
    KIND_DROPPED   = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_ROWS    = 2'd1;
  localparam logic [1:0] ST_WIDTH_DIFF = 2'd2;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            data;
    logic [ColOutBits-1:0] col;
    logic [RowOutBits-1:0] row;
    logic [1:0]            status;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/csv_field_tokenizer.sv -----
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming csv field splitter
// Splits a byte stream into field bytes, field ends and row ends, handles
// quoted sections with doubled-quote escapes and reports a stream status.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                                    tuser      tlast
//  s_axis   in   byte_in[7:0]                             cmd        -
//  m_axis   out  byte_out, column, row, status, zero pad  kind[2:0]  last
//
//  flow: a word is parsed in the cycle it is accepted, its 0 to 3 results go
//  into a three-entry result buffer that drains one result per cycle while
//  m_axis_tready is high; a word that makes at most one result sustains one
//  word per cycle then, a word with more holds the input until one is left
//  reset: all parser flags and counters are cleared, the result buffer is emptied
//  stalls: the next word is taken in the same cycle the last buffered result
//  is taken, so a downstream stall backs up into s_axis_tready
//
`default_nettype none

module csv_field_tokenizer #(
  parameter int unsigned COLUMN_BITS = csvft_pkg::ColumnBitsDef,
  parameter int unsigned ROW_BITS    = csvft_pkg::RowBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tuser,   // [0] cmd (1 = end of stream)
  // result words
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [55:0] m_axis_tdata,   // [7:0] byte_out, [23:8] column_index,
                                           // [47:24] row_index, [49:48] status,
                                           // [55:50] zero
  output      logic [2:0]  m_axis_tuser,   // [2:0] kind
  output      logic        m_axis_tlast    // last result of its input word
);

  import csvft_pkg::*;

  // parser state
  logic                   inq_q, inq_d;       // inside a quoted section
  logic                   qp_q, qp_d;         // quote seen inside quotes, next byte decides
  logic                   fhb_q, fhb_d;       // field holds bytes
  logic                   fnb_q, fnb_d;       // field holds a non-blank byte
  logic [COLUMN_BITS-1:0] cols_q, cols_d;     // fields closed in the current row
  logic [COLUMN_BITS-1:0] frw_q, frw_d;       // width of the first row
  logic [ROW_BITS-1:0]    rows_q, rows_d;     // rows closed so far
  logic                   mm_q, mm_d;         // some row differs from the first

  // result buffer, entry 0 is the head
  res_t       buf_q [MaxResults];
  res_t       buf_d [MaxResults];
  logic [1:0] cnt_q, cnt_d;

  res_t       cand [MaxResults];
  logic [MaxResults-1:0] cand_v;
  res_t       slot [MaxResults];
  logic [1:0] n_res;

  logic       s_acc, m_acc, is_end, esc, inq_eff, blank;
  logic [7:0] b;
  logic [COLUMN_BITS-1:0] cols_inc, cols_end;
  logic [ROW_BITS-1:0]    rows_inc, rows_end;
  logic                   mm_end;
  logic [1:0]             st_end;

  // clip a column count onto the 16-bit result field
  function automatic logic [ColOutBits-1:0] clip_col(logic [COLUMN_BITS-1:0] v);
    logic [COLUMN_BITS+ColOutBits-1:0] ext;
    ext = (COLUMN_BITS+ColOutBits)'(v);
    if (ext > (COLUMN_BITS+ColOutBits)'({ColOutBits{1'b1}})) begin
      return {ColOutBits{1'b1}};
    end
    return ext[ColOutBits-1:0];
  endfunction

  // clip a row count onto the 24-bit result field
  function automatic logic [RowOutBits-1:0] clip_row(logic [ROW_BITS-1:0] v);
    logic [ROW_BITS+RowOutBits-1:0] ext;
    ext = (ROW_BITS+RowOutBits)'(v);
    if (ext > (ROW_BITS+RowOutBits)'({RowOutBits{1'b1}})) begin
      return {RowOutBits{1'b1}};
    end
    return ext[RowOutBits-1:0];
  endfunction

  function automatic res_t mk_res(kind_e k, logic [7:0] d, logic [COLUMN_BITS-1:0] c,
                                  logic [ROW_BITS-1:0] r, logic [1:0] st);
    res_t x;
    x.kind   = k;
    x.data   = d;
    x.col    = clip_col(c);
    x.row    = clip_row(r);
    x.status = st;
    x.last   = 1'b0;
    return x;
  endfunction

  // handshakes: a new word may land while the final buffered result leaves
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  assign b        = s_axis_tdata;
  assign is_end   = s_axis_tuser || (b == CH_NUL);
  assign blank    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  // saturating counter steps
  assign cols_inc = (cols_q == {COLUMN_BITS{1'b1}}) ? cols_q : cols_q + 1'b1;
  assign rows_inc = (rows_q == {ROW_BITS{1'b1}}) ? rows_q : rows_q + 1'b1;

  // parse one word: candidate results and next state
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      cand[i] = mk_res(KIND_BYTE, 8'h00, '0, '0, ST_OK);
    end
    cand_v   = '0;
    inq_d    = inq_q;
    qp_d     = qp_q;
    fhb_d    = fhb_q;
    fnb_d    = fnb_q;
    cols_d   = cols_q;
    frw_d    = frw_q;
    rows_d   = rows_q;
    mm_d     = mm_q;
    esc      = 1'b0;
    inq_eff  = inq_q;
    cols_end = cols_q;
    rows_end = rows_q;
    mm_end   = mm_q;
    st_end   = ST_OK;
    if (!is_end) begin
      // a pending quote followed by a quote is an escaped quote,
      // followed by anything else it closes the section first
      esc     = qp_q && (b == CH_QUOTE);
      inq_eff = inq_q && !(qp_q && (b != CH_QUOTE));
      qp_d    = 1'b0;
      inq_d   = inq_eff;
      if (esc) begin
        cand[0]   = mk_res(KIND_BYTE, CH_QUOTE, cols_q, rows_q, ST_OK);
        cand_v[0] = 1'b1;
        fhb_d     = 1'b1;
        fnb_d     = 1'b1;
      end else if (b == CH_QUOTE) begin
        if (inq_eff) begin
          qp_d = 1'b1;
        end else begin
          inq_d = 1'b1;
        end
      end else if ((b == CH_COMMA) && !inq_eff) begin
        cand[0]   = mk_res(KIND_FIELD_END, 8'h00, cols_q, rows_q, ST_OK);
        cand_v[0] = 1'b1;
        cols_d    = cols_inc;
        fhb_d     = 1'b0;
        fnb_d     = 1'b0;
      end else if ((b == CH_NEWLINE) && !inq_eff) begin
        cand[0]   = mk_res(KIND_FIELD_END, 8'h00, cols_q, rows_q, ST_OK);
        cand[1]   = mk_res(KIND_ROW_END, 8'h00, cols_inc, rows_q, ST_OK);
        cand_v[1:0] = 2'b11;
        fhb_d     = 1'b0;
        fnb_d     = 1'b0;
        // the first row sets the reference width
        if (rows_q == '0) begin
          frw_d = cols_inc;
        end else if (cols_inc != frw_q) begin
          mm_d = 1'b1;
        end
        rows_d = rows_inc;
        cols_d = '0;
      end else begin
        cand[0]   = mk_res(KIND_BYTE, b, cols_q, rows_q, ST_OK);
        cand_v[0] = 1'b1;
        fhb_d     = 1'b1;
        if (!blank) begin
          fnb_d = 1'b1;
        end
      end
    end else begin
      // end of stream: close or drop the open field, close the row, report
      if (fnb_q) begin
        cand[0]   = mk_res(KIND_FIELD_END, 8'h00, cols_q, rows_q, ST_OK);
        cand_v[0] = 1'b1;
        cols_end  = cols_inc;
      end else if (fhb_q || (cols_q != '0)) begin
        cand[0]   = mk_res(KIND_DROPPED, 8'h00, cols_q, rows_q, ST_OK);
        cand_v[0] = 1'b1;
      end
      if (cols_end != '0) begin
        cand[1]   = mk_res(KIND_ROW_END, 8'h00, cols_end, rows_q, ST_OK);
        cand_v[1] = 1'b1;
        rows_end  = rows_inc;
        if ((rows_q != '0) && (cols_end != frw_q)) begin
          mm_end = 1'b1;
        end
      end
      if (rows_end == '0) begin
        st_end = ST_NO_ROWS;
      end else if (mm_end) begin
        st_end = ST_WIDTH_DIFF;
      end
      cand[2]   = mk_res(KIND_DONE, 8'h00, '0, rows_end, st_end);
      cand_v[2] = 1'b1;
      // back to the reset state for the next stream
      inq_d  = 1'b0;
      qp_d   = 1'b0;
      fhb_d  = 1'b0;
      fnb_d  = 1'b0;
      cols_d = '0;
      frw_d  = '0;
      rows_d = '0;
      mm_d   = 1'b0;
    end
  end

  // pack valid candidates to the front and flag the final one
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      slot[i] = cand[i];
    end
    n_res = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      if (cand_v[i]) begin
        slot[n_res] = cand[i];
        n_res       = n_res + 2'd1;
      end
    end
    if (n_res != 2'd0) begin
      slot[n_res - 2'd1].last = 1'b1;
    end
  end

  // result buffer load and shift
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      buf_d[i] = buf_q[i];
    end
    cnt_d = cnt_q;
    if (s_acc) begin
      for (int i = 0; i < MaxResults; i++) begin
        buf_d[i] = slot[i];
      end
      cnt_d = n_res;
    end else if (m_acc) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q  <= 1'b0;
      qp_q   <= 1'b0;
      fhb_q  <= 1'b0;
      fnb_q  <= 1'b0;
      cols_q <= '0;
      frw_q  <= '0;
      rows_q <= '0;
      mm_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (s_acc) begin
        inq_q  <= inq_d;
        qp_q   <= qp_d;
        fhb_q  <= fhb_d;
        fnb_q  <= fnb_d;
        cols_q <= cols_d;
        frw_q  <= frw_d;
        rows_q <= rows_d;
        mm_q   <= mm_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  assign m_axis_tuser = buf_q[0].kind;
  assign m_axis_tlast = buf_q[0].last;
  assign m_axis_tdata = {6'b0, buf_q[0].status, buf_q[0].row, buf_q[0].col, buf_q[0].data};

`ifndef SYNTHESIS
  // buffer takes no new word while it holds three results
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || !s_axis_tready)
    else $error("result buffer accepting while full");

  // a pending quote only exists inside a quoted section
  a_qp_in_quotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qp_q || inq_q)
    else $error("quote pending outside quoted section");

  // stream done is always the final result of its word
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_DONE)) |-> m_axis_tlast)
    else $error("stream done not marked last");

  // an end of stream word returns the parser to its reset state
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && is_end) |=> (rows_q == '0 && cols_q == '0 && !inq_q && !mm_q))
    else $error("parser state not cleared at stream end");

  // an end of stream word leaves the buffer non-empty
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && is_end) |=> m_axis_tvalid)
    else $error("stream end produced no result");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stream-level test of the csv field tokenizer
// Drives csv byte words into the slave side and checks every result word on
// the master side against an in-bench tokenizer model, with random gaps on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import csvft_pkg::*;

  // clock, reset and dut ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] byte_in
  logic        s_axis_tuser  = 1'b0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;           // [7:0] byte, [23:8] column, [47:24] row,
                                       // [49:48] status, [55:50] zero
  logic [2:0]  m_axis_tuser;           // [2:0] kind
  logic        m_axis_tlast;

  // tokenizer model state
  logic        tok_in_quote;
  logic        tok_quote_pend;
  logic        tok_has_bytes;
  logic        tok_nonblank;
  logic [15:0] tok_columns;
  logic [15:0] tok_first_width;
  logic [23:0] tok_rows;
  logic        tok_width_diff;

  // result words still to come, oldest first
  res_t token_queue[$];

  bit idle_on        = 1'b1;  // random gaps on both sides
  int hold_req       = 0;     // receiver hold-off request, in cycles
  int hold_left      = 0;
  int mismatch_count = 0;
  int words_sent     = 0;     // input words taken so far

  csv_field_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #(12 * 200000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tokenizer model
  // ---------------------------------------------------------------------------

  function automatic void clear_tokenizer();
    tok_in_quote    = 1'b0;
    tok_quote_pend  = 1'b0;
    tok_has_bytes   = 1'b0;
    tok_nonblank    = 1'b0;
    tok_columns     = '0;
    tok_first_width = '0;
    tok_rows        = '0;
    tok_width_diff  = 1'b0;
  endfunction

  function automatic res_t make_token(kind_e k, logic [7:0] d, logic [15:0] c,
                                      logic [23:0] rw, logic [1:0] st);
    res_t t;
    t.kind   = k;
    t.data   = d;
    t.col    = c;
    t.row    = rw;
    t.status = st;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // counters stick at all ones
  function automatic void close_field();
    if (tok_columns != '1) tok_columns = tok_columns + 1'b1;
    tok_has_bytes = 1'b0;
    tok_nonblank  = 1'b0;
  endfunction

  function automatic void close_row();
    if (tok_rows == '0) tok_first_width = tok_columns;
    else if (tok_columns != tok_first_width) tok_width_diff = 1'b1;
    if (tok_rows != '1) tok_rows = tok_rows + 1'b1;
    tok_columns = '0;
  endfunction

  // works out the result words of one input word and queues them
  function automatic void tokenize_word(logic cmd, logic [7:0] b);
    res_t       r[MaxResults];
    int         n;
    bit         handled;
    logic [1:0] st;
    n       = 0;
    handled = 1'b0;
    if (!cmd && b != CH_NUL) begin
      // a quote after a quote inside a section is a literal quote
      if (tok_quote_pend) begin
        tok_quote_pend = 1'b0;
        if (b == CH_QUOTE) begin
          r[n] = make_token(KIND_BYTE, CH_QUOTE, tok_columns, tok_rows, ST_OK);
          n++;
          tok_has_bytes = 1'b1;
          tok_nonblank  = 1'b1;
          handled       = 1'b1;
        end else begin
          tok_in_quote = 1'b0;
        end
      end
      if (!handled) begin
        if (b == CH_QUOTE) begin
          if (tok_in_quote) tok_quote_pend = 1'b1;
          else tok_in_quote = 1'b1;
        end else if (b == CH_COMMA && !tok_in_quote) begin
          r[n] = make_token(KIND_FIELD_END, 8'h00, tok_columns, tok_rows, ST_OK);
          n++;
          close_field();
        end else if (b == CH_NEWLINE && !tok_in_quote) begin
          r[n] = make_token(KIND_FIELD_END, 8'h00, tok_columns, tok_rows, ST_OK);
          n++;
          close_field();
          r[n] = make_token(KIND_ROW_END, 8'h00, tok_columns, tok_rows, ST_OK);
          n++;
          close_row();
        end else begin
          r[n] = make_token(KIND_BYTE, b, tok_columns, tok_rows, ST_OK);
          n++;
          tok_has_bytes = 1'b1;
          if (!is_blank(b)) tok_nonblank = 1'b1;
        end
      end
    end else begin
      // end of stream: judge the open field, close the row, give the status
      if (tok_nonblank) begin
        r[n] = make_token(KIND_FIELD_END, 8'h00, tok_columns, tok_rows, ST_OK);
        n++;
        close_field();
      end else if (tok_has_bytes || tok_columns != '0) begin
        r[n] = make_token(KIND_DROPPED, 8'h00, tok_columns, tok_rows, ST_OK);
        n++;
        tok_has_bytes = 1'b0;
        tok_nonblank  = 1'b0;
      end
      if (tok_columns != '0) begin
        r[n] = make_token(KIND_ROW_END, 8'h00, tok_columns, tok_rows, ST_OK);
        n++;
        close_row();
      end
      st = (tok_rows == '0) ? ST_NO_ROWS : (tok_width_diff ? ST_WIDTH_DIFF : ST_OK);
      r[n] = make_token(KIND_DONE, 8'h00, 16'h0000, tok_rows, st);
      n++;
      clear_tokenizer();
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) token_queue.push_back(r[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_token();
    res_t want;
    if (token_queue.size() == 0) begin
      report_mismatch("unexpected result word, kind", 32'(m_axis_tuser), 32'h0);
      return;
    end
    want = token_queue.pop_front();
    if (m_axis_tuser !== want.kind)
      report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
    if (m_axis_tdata[7:0] !== want.data)
      report_mismatch("byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
    if (m_axis_tdata[23:8] !== want.col)
      report_mismatch("column", 32'(m_axis_tdata[23:8]), 32'(want.col));
    if (m_axis_tdata[47:24] !== want.row)
      report_mismatch("row", 32'(m_axis_tdata[47:24]), 32'(want.row));
    if (m_axis_tdata[49:48] !== want.status)
      report_mismatch("status", 32'(m_axis_tdata[49:48]), 32'(want.status));
    if (m_axis_tdata[55:50] !== 6'd0)
      report_mismatch("padding", 32'(m_axis_tdata[55:50]), 32'h0);
    if (m_axis_tlast !== want.last)
      report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
  endtask

  // receiver: checks each accepted word, then picks next cycle's tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_token();
    if (hold_left > 0) begin
      // long hold-off so the result buffer fills and input stalls
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_on || ($urandom_range(99) >= 23);
    end
  end

  // hold-off length, counted down one cycle at a time
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req  = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offers one word, returns at the edge where it is taken; valid stays high
  task automatic send_word(logic cmd, logic [7:0] b);
    // random gap, each idle check succeeds with a chance of 23 in a hundred
    while (idle_on && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    // expectations go in before the word can be taken
    tokenize_word(cmd, b);
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // end of stream either by cmd or by a zero byte
  task automatic end_stream(bit by_nul);
    if (by_nul) send_word(1'b0, CH_NUL);
    else send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (token_queue.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (token_queue.size() != 0) begin
      report_mismatch("results never arrived, count", 32'(token_queue.size()), 32'h0);
      token_queue.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // unquoted content byte, blanks more often than chance
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0)
        c = $urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13));
      else
        c = 8'($urandom_range(1, 255));
    end while (c == CH_QUOTE || c == CH_COMMA || c == CH_NEWLINE);
    return c;
  endfunction

  // quoted content byte, with commas, newlines and quotes often
  function automatic logic [7:0] quoted_char();
    case ($urandom_range(4))
      0: return CH_COMMA;
      1: return CH_NEWLINE;
      2: return CH_QUOTE;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_field();
    int         len;
    logic [7:0] c;
    len = $urandom_range(0, 4);
    if ($urandom_range(3) == 0) begin
      send_word(1'b0, CH_QUOTE);
      for (int i = 0; i < len; i++) begin
        c = quoted_char();
        send_word(1'b0, c);
        // doubled quote inside a section
        if (c == CH_QUOTE) send_word(1'b0, CH_QUOTE);
      end
      send_word(1'b0, CH_QUOTE);
      // now and then junk after the closing quote
      if ($urandom_range(9) == 0) send_word(1'b0, plain_char());
    end else begin
      for (int i = 0; i < len; i++) send_word(1'b0, plain_char());
    end
  endtask

  task automatic send_record(int width);
    for (int f = 0; f < width; f++) begin
      send_field();
      if (f < width - 1) send_word(1'b0, CH_COMMA);
    end
    send_word(1'b0, CH_NEWLINE);
  endtask

  // a well-formed stream: rows of one width, sometimes a wider or narrower one
  task automatic send_csv_stream();
    int rows;
    int width;
    rows  = $urandom_range(0, 4);
    width = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++)
      send_record(($urandom_range(99) < 15) ? $urandom_range(1, 5) : width);
    // trailing row without newline
    if ($urandom_range(1)) begin
      send_field();
      if ($urandom_range(1)) send_word(1'b0, CH_COMMA);
    end
    end_stream($urandom_range(1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // end on empty input: no rows
    end_stream(1'b0);
    // escaped quote, quoted comma, empty last field
    send_text("ab,\"c\"\"d,e\",\n");
    // extreme bytes, then a blank-only field dropped at a zero byte,
    // the short row makes the widths differ
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h01);
    send_text(", \t");
    end_stream(1'b1);
    // unterminated quote at the end, cmd with a nonzero byte
    send_text("\"x");
    send_word(1'b1, 8'hFF);
    // empty field after a comma at the end is reported as dropped
    send_text("a,");
    end_stream(1'b0);
    wait_for_results();
  endtask

  task automatic test_random_streams();
    int stop_at;
    stop_at = words_sent + 60;
    while (words_sent < stop_at) send_csv_stream();
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    int stop_at;
    idle_on = 1'b0;
    stop_at = words_sent + 40;
    while (words_sent < stop_at) send_csv_stream();
    wait_for_results();
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 150;
    repeat (6) send_text("x,yz\n");
    end_stream(1'b0);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // random bytes weighted toward the special characters, broken sequences
  task automatic test_noise();
    logic [7:0] b;
    repeat (40) begin
      case ($urandom_range(5))
        0: b = CH_QUOTE;
        1: b = CH_COMMA;
        2: b = CH_NEWLINE;
        3: b = ($urandom_range(3) == 0) ? CH_NUL : CH_SPACE;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_word($urandom_range(19) == 0, b);
    end
    end_stream(1'b0);
    wait_for_results();
  endtask

  initial begin
    clear_tokenizer();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_streams();
    test_back_to_back();
    test_backpressure();
    test_noise();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
